@@ rtl/csvt_pkg.sv @@
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types, constants and helpers of the CSV line field tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int unsigned WsDepthDef = 16;
  localparam int unsigned CmdCntW    = 6;
  localparam int unsigned QDepth     = 2;

  localparam logic [7:0] DelimRst = 8'd44;
  localparam logic [7:0] QuoteRst = 8'd34;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_QUOTE,
    MODE_QSEEN
  } mode_e;

  typedef enum logic [1:0] {
    CMD_WS,
    CMD_EMIT,
    CMD_END
  } cmd_kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_QUOTE,
    B_WS,
    B_BYTE,
    B_END
  } back_st_e;

  typedef enum logic {
    REG_DELIM = 1'b0,
    REG_QUOTE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [7:0]          data;
    logic [CmdCntW-1:0]  cnt;
    logic                held;
    logic                has_byte;
    logic                ovf;
  } cmd_t;

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32) || (c == 8'd133) ||
           (c == 8'd160);
  endfunction

endpackage

@@ rtl/csv_line_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// csv_line_field_tokenizer
// CSV field splitter with quote handling and whitespace trimming.
// ----------------------------------------------------------------------------
// Input: one byte of a line per item (push/full), or an end-of-line marker.
// Output: a queue-like result port (empty/pop); each field is a run of
// content bytes followed by one field-end result. run_last_o flags the last
// result caused by an input item. delimiter/quote bytes are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only while the block is
// idle; the block itself does not enforce this. A taken item's command is
// queued, and its first result is registered when the sequencer is free.
// Throughput: one item per cycle while pop keeps up and each item yields at
// most one result; an item that flushes a held quote and n pending whitespace
// bytes occupies the output sequencer for the quote, each byte and the content
// byte, and a two-entry command queue lets the parser run ahead meanwhile.
// Reset: parser state cleared, delimiter = comma, quote = double quote,
// no results pending.
// Stall: with pop low the result register holds, the sequencer and queue
// fill, and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module csv_line_field_tokenizer #(
  parameter int unsigned WS_DEPTH = csvt_pkg::WsDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_line_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       field_end_o,
  output logic       run_last_o,
  output logic       ws_overflow_o
);
  import csvt_pkg::*;

  logic [7:0] delim_q;
  logic [7:0] quote_q;
  logic       cmd_push;
  cmd_t       cmd_in;
  cmd_t       cmd_out;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimRst;
      quote_q <= QuoteRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DELIM: delim_q <= cfg_data_i;
        REG_QUOTE: quote_q <= cfg_data_i;
        default:   delim_q <= delim_q;
      endcase
    end
  end

  csvt_front #(
    .WS_DEPTH(WS_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i        (push),
    .in_byte_i,
    .end_of_line_i,
    .delim_i       (delim_q),
    .quote_i       (quote_q),
    .q_full_i      (q_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  csvt_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i    (cmd_push),
    .wdata_i (cmd_in),
    .rd_i    (q_pop),
    .rdata_o (cmd_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  csvt_back #(
    .WS_DEPTH(WS_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .quote_i     (quote_q),
    .q_empty_i   (q_empty),
    .q_cmd_i     (cmd_out),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_byte_o  (out_byte_o),
    .res_end_o   (field_end_o),
    .res_last_o  (run_last_o),
    .res_ovf_o   (ws_overflow_o)
  );

  assign full  = q_full;
  assign empty = !res_valid;

endmodule

@@ rtl/csvt_front.sv @@
// ----------------------------------------------------------------------------
// csvt_front
// Parser front end: tracks quoting and trimming state per item and issues
// at most one command per item to the back end.
// ----------------------------------------------------------------------------
module csvt_front #(
  parameter int unsigned WS_DEPTH = csvt_pkg::WsDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_line_i,
  input  logic [7:0]       delim_i,
  input  logic [7:0]       quote_i,
  input  logic             q_full_i,
  output logic             cmd_push_o,
  output csvt_pkg::cmd_t   cmd_o
);
  import csvt_pkg::*;

  localparam int unsigned CntW = $clog2(WS_DEPTH + 1);

  mode_e            mode_q, mode_d;
  logic             touched_q, touched_d;
  logic             started_q, started_d;
  logic             strip_q, strip_d;
  logic             held_q, held_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;

  logic accept;
  logic keep;
  logic close;
  logic clear;
  logic fire;
  logic [7:0] c;

  assign accept = push_i && !q_full_i;
  assign c      = in_byte_i;

  always_comb begin
    mode_d     = mode_q;
    touched_d  = touched_q;
    started_d  = started_q;
    strip_d    = strip_q;
    held_d     = held_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    keep       = 1'b0;
    close      = 1'b0;
    clear      = 1'b0;
    fire       = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.ovf  = ovf_q;

    if (accept) begin
      if (end_of_line_i) begin
        close  = touched_q;
        clear  = 1'b1;
        mode_d = MODE_NORMAL;
      end else begin
        unique case (mode_q)
          MODE_QUOTE: begin
            keep = 1'b1;
            if (c == quote_i) mode_d = MODE_QSEEN;
          end
          MODE_QSEEN: begin
            if (c == quote_i) begin
              mode_d = MODE_QUOTE;
            end else begin
              mode_d = MODE_NORMAL;
              if (c == delim_i) begin
                close = 1'b1;
                clear = 1'b1;
              end else begin
                keep = 1'b1;
              end
            end
          end
          default: begin
            mode_d = MODE_NORMAL;
            if (c == delim_i) begin
              close = 1'b1;
              clear = 1'b1;
            end else begin
              keep = 1'b1;
              if (c == quote_i) mode_d = MODE_QUOTE;
            end
          end
        endcase
      end
    end

    if (close) begin
      cmd_push_o = 1'b1;
      cmd_o.kind = CMD_END;
    end

    if (keep) begin
      touched_d = 1'b1;
      if (!started_q) begin
        if (!is_space(c)) begin
          started_d = 1'b1;
          if (c == quote_i) begin
            strip_d = 1'b1;
          end else begin
            cmd_push_o     = 1'b1;
            cmd_o.kind     = CMD_EMIT;
            cmd_o.data     = c;
            cmd_o.has_byte = 1'b1;
          end
        end
      end else if (is_space(c)) begin
        if (cnt_q < CntW'(WS_DEPTH)) begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_WS;
          cmd_o.data = c;
          cmd_o.cnt  = CmdCntW'(cnt_q);
          cnt_d      = cnt_q + CntW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        fire           = strip_q && (c == quote_i);
        held_d         = fire;
        cnt_d          = '0;
        cmd_o.kind     = CMD_EMIT;
        cmd_o.data     = c;
        cmd_o.cnt      = CmdCntW'(cnt_q);
        cmd_o.held     = held_q;
        cmd_o.has_byte = !fire;
        cmd_push_o     = held_q || (cnt_q != '0) || !fire;
      end
    end

    if (clear) begin
      touched_d = 1'b0;
      started_d = 1'b0;
      strip_d   = 1'b0;
      held_d    = 1'b0;
      cnt_d     = '0;
      ovf_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      touched_q <= 1'b0;
      started_q <= 1'b0;
      strip_q   <= 1'b0;
      held_q    <= 1'b0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      touched_q <= touched_d;
      started_q <= started_d;
      strip_q   <= strip_d;
      held_q    <= held_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

@@ rtl/csvt_fifo.sv @@
// ----------------------------------------------------------------------------
// csvt_fifo
// Short command queue between the parser front end and the output back end.
// ----------------------------------------------------------------------------
module csvt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  csvt_pkg::cmd_t wdata_i,
  input  logic           rd_i,
  output csvt_pkg::cmd_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import csvt_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) wptr_d = (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    if (do_rd) rptr_d = (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    if (do_wr && !do_rd) cnt_d = cnt_q + CntW'(1);
    else if (!do_wr && do_rd) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(QDepth))
    else $error("command queue count beyond depth");

endmodule

@@ rtl/csvt_back.sv @@
// ----------------------------------------------------------------------------
// csvt_back
// Output back end: holds pending whitespace and expands emit commands into
// a held quote, the buffered whitespace and the content byte.
// ----------------------------------------------------------------------------
module csvt_back #(
  parameter int unsigned WS_DEPTH = csvt_pkg::WsDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     quote_i,
  input  logic           q_empty_i,
  input  csvt_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           res_valid_o,
  output logic [7:0]     res_byte_o,
  output logic           res_end_o,
  output logic           res_last_o,
  output logic           res_ovf_o
);
  import csvt_pkg::*;

  localparam int unsigned IdxW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

  logic [7:0]          ws_mem_q [WS_DEPTH];
  back_st_e            st_q, st_d, ph;
  cmd_t                cmd_q, cur;
  logic [CmdCntW-1:0]  idx_q, idx_d, idx_cur;
  logic                idle, slot_free, step, last_ws, ws_wr;

  logic                out_v_q, out_v_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_end_q, out_end_d;
  logic                out_last_q, out_last_d;
  logic                out_ovf_q, out_ovf_d;

  assign idle      = (st_q == B_IDLE);
  assign cur       = idle ? q_cmd_i : cmd_q;
  assign idx_cur   = idle ? '0 : idx_q;
  assign slot_free = !out_v_q || pop_i;
  assign last_ws   = (idx_cur == (cur.cnt - CmdCntW'(1)));

  always_comb begin
    ph = st_q;
    if (idle) begin
      ph = B_IDLE;
      if (!q_empty_i) begin
        unique case (q_cmd_i.kind)
          CMD_END:  ph = B_END;
          CMD_EMIT: ph = q_cmd_i.held ? B_QUOTE :
                         ((q_cmd_i.cnt != '0) ? B_WS : B_BYTE);
          default:  ph = B_IDLE;
        endcase
      end
    end
  end

  assign step    = slot_free && (ph != B_IDLE);
  assign ws_wr   = idle && !q_empty_i && (q_cmd_i.kind == CMD_WS);
  assign q_pop_o = idle && !q_empty_i &&
                   (step || ((q_cmd_i.kind != CMD_EMIT) && (q_cmd_i.kind != CMD_END)));

  always_comb begin
    st_d       = st_q;
    idx_d      = idx_q;
    out_v_d    = out_v_q && !pop_i;
    out_byte_d = out_byte_q;
    out_end_d  = out_end_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    if (step) begin
      out_v_d    = 1'b1;
      out_ovf_d  = cur.ovf;
      out_end_d  = 1'b0;
      unique case (ph)
        B_QUOTE: begin
          out_byte_d = quote_i;
          out_last_d = (cur.cnt == '0) && !cur.has_byte;
          idx_d      = '0;
          st_d       = (cur.cnt != '0) ? B_WS : (cur.has_byte ? B_BYTE : B_IDLE);
        end
        B_WS: begin
          out_byte_d = ws_mem_q[idx_cur[IdxW-1:0]];
          out_last_d = last_ws && !cur.has_byte;
          idx_d      = idx_cur + CmdCntW'(1);
          st_d       = last_ws ? (cur.has_byte ? B_BYTE : B_IDLE) : B_WS;
        end
        B_BYTE: begin
          out_byte_d = cur.data;
          out_last_d = 1'b1;
          st_d       = B_IDLE;
        end
        default: begin
          out_byte_d = '0;
          out_end_d  = 1'b1;
          out_last_d = 1'b1;
          st_d       = B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ws_wr) ws_mem_q[q_cmd_i.cnt[IdxW-1:0]] <= q_cmd_i.data;
    if (idle) cmd_q <= q_cmd_i;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_IDLE;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_byte_o  = out_byte_q;
  assign res_end_o   = out_end_q;
  assign res_last_o  = out_last_q;
  assign res_ovf_o   = out_ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_end_q) |-> (out_last_q && (out_byte_q == '0)))
    else $error("field end must be last and carry no byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_WS) |-> (idx_q < cmd_q.cnt))
    else $error("whitespace index past pending count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !out_last_d) |=> (st_q != B_IDLE))
    else $error("sequence ended without last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && out_last_d) |=> (st_q == B_IDLE))
    else $error("sequence continues after last result");

endmodule
